### design/edfc_pkg.sv
package edfc_pkg;

  // Format constants
  localparam int unsigned ExtBias = 16383;
  localparam int unsigned DblBias = 1023;
  localparam logic [14:0] ExtExpMax = 15'h7fff;
  localparam logic [10:0] DblExpMax = 11'h7ff;
  localparam logic [14:0] BiasDiff = 15'(ExtBias - DblBias);
  // Smallest extended exponent that overflows a double: DblExpMax + BiasDiff
  localparam logic [14:0] ExtExpOvf = 15'(32'(DblExpMax) + (ExtBias - DblBias));
  localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ExtQnan = 64'hc000_0000_0000_0000;
  localparam logic [62:0] DblInfMag = 63'h7ff0_0000_0000_0000;
  localparam logic [62:0] DblQnanMag = 63'h7ff8_0000_0000_0000;

  // Direction codes
  typedef enum logic {
    OP_EXT_TO_DBL = 1'b0,
    OP_DBL_TO_EXT = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] ext_mantissa_in;
    logic [15:0] ext_sign_exp_in;
    logic [63:0] double_in;
  } in_t;

  typedef struct packed {
    logic [63:0] double_out;
    logic [63:0] ext_mantissa_out;
    logic [15:0] ext_sign_exp_out;
  } out_t;

endpackage

### design/edfc_ext_to_dbl.sv
module edfc_ext_to_dbl (
  input  logic [63:0] mantissa,
  input  logic [15:0] sign_exp,
  output logic [63:0] dbl
);

  logic        sign;
  logic [14:0] exp_ext;
  logic [14:0] exp_rebias;
  logic        nan_bits;

  assign sign       = sign_exp[15];
  assign exp_ext    = sign_exp[14:0];
  assign exp_rebias = exp_ext - edfc_pkg::BiasDiff;
  assign nan_bits   = |mantissa[62:61];

  // Classify the exponent and build the double
  always_comb begin
    if (exp_ext == edfc_pkg::ExtExpMax) begin
      dbl = {sign, nan_bits ? edfc_pkg::DblQnanMag : edfc_pkg::DblInfMag};
    end else if (exp_ext <= edfc_pkg::BiasDiff) begin
      // zero or underflow: flush to signed zero
      dbl = {sign, 63'd0};
    end else if (exp_ext >= edfc_pkg::ExtExpOvf) begin
      dbl = {sign, edfc_pkg::DblInfMag};
    end else begin
      // truncate the fraction
      dbl = {sign, exp_rebias[10:0], mantissa[62:11]};
    end
  end

endmodule

### design/edfc_dbl_to_ext.sv
module edfc_dbl_to_ext (
  input  logic [63:0] dbl,
  output logic [63:0] mantissa,
  output logic [15:0] sign_exp
);

  logic        sign;
  logic [10:0] exp_dbl;
  logic [51:0] frac;

  assign sign    = dbl[63];
  assign exp_dbl = dbl[62:52];
  assign frac    = dbl[51:0];

  // Classify the double and build the extended value
  always_comb begin
    if (dbl[62:0] == 63'd0) begin
      mantissa = 64'd0;
      sign_exp = {sign, 15'd0};
    end else if (exp_dbl == edfc_pkg::DblExpMax) begin
      mantissa = (frac == 52'd0) ? edfc_pkg::TopBit : edfc_pkg::ExtQnan;
      sign_exp = {sign, edfc_pkg::ExtExpMax};
    end else if (exp_dbl != 11'd0) begin
      // normal: explicit integer bit, rebiased exponent
      mantissa = {1'b1, frac, 11'd0};
      sign_exp = {sign, 15'(exp_dbl) + edfc_pkg::BiasDiff};
    end else begin
      // denormal: exponent stays zero
      mantissa = {1'b0, frac, 11'd0};
      sign_exp = {sign, 15'd0};
    end
  end

endmodule

### design/extended_double_float_convert.sv
// Converts one operand per transaction between x87 80-bit extended and
// IEEE double. in_data.operation picks the direction: extended to double
// fills double_out and zeroes the extended fields; double to extended fills
// ext_mantissa_out and ext_sign_exp_out and zeroes double_out.
// Both channels use valid/stall: a transaction moves on a rising edge with
// valid high and stall low.
// The input register loads at the accepting edge; the result register loads
// from it once the result register is empty or out_stall is low.
// Throughput: one transaction per cycle while out_stall is low; the
// conversion is a single pass of field rebias and selection between the two
// registers. When out_stall is high and the result register is full, it
// holds; the input register still fills if it is empty, and in_stall rises
// only once both stages hold a transaction.
// Reset (rst, synchronous, active high) empties both stages; out_valid is
// low in the cycle after reset.
module extended_double_float_convert (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  edfc_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output edfc_pkg::out_t   out_data
);

  logic           s1_valid;
  edfc_pkg::in_t  s1_data;
  logic           s2_load;
  logic           s1_load;
  logic [63:0]    dbl_res;
  logic [63:0]    ext_mant_res;
  logic [15:0]    ext_se_res;
  edfc_pkg::out_t res_next;

  // Advance control
  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
    if (s1_load) begin
      s1_data <= in_data;
    end
  end

  edfc_ext_to_dbl u_ext_to_dbl (
    .mantissa (s1_data.ext_mantissa_in),
    .sign_exp (s1_data.ext_sign_exp_in),
    .dbl      (dbl_res)
  );

  edfc_dbl_to_ext u_dbl_to_ext (
    .dbl      (s1_data.double_in),
    .mantissa (ext_mant_res),
    .sign_exp (ext_se_res)
  );

  // Select the direction, zero the unused fields
  always_comb begin
    if (s1_data.operation == edfc_pkg::OP_DBL_TO_EXT) begin
      res_next.double_out       = 64'd0;
      res_next.ext_mantissa_out = ext_mant_res;
      res_next.ext_sign_exp_out = ext_se_res;
    end else begin
      res_next.double_out       = dbl_res;
      res_next.ext_mantissa_out = 64'd0;
      res_next.ext_sign_exp_out = 16'd0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s2_load) begin
      out_data <= res_next;
    end
  end

  // Input stall only when both stages are occupied and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("in_stall raised with a free stage");

  // An accepted transaction lands in the input register
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction lost");

  // A blocked input register keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> (s1_valid && $stable(s1_data)))
    else $error("input register dropped a waiting transaction");

  // Only one direction's fields carry data
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.ext_sign_exp_out != 16'd0 ||
                   out_data.ext_mantissa_out != 64'd0)) |-> (out_data.double_out == 64'd0))
    else $error("both result directions populated");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("out_valid high after reset");

endmodule
